@@ rtl/core/counting_semaphore_fifo_waiters_macros.svh @@
// Assertion macros used by the semaphore top level.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_MACROS_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define CSFW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, checked out of reset.
`define CSFW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define CSFW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSFW_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/csfw_pkg.sv @@
// Shared types and constants of the counting semaphore.
`timescale 1ns / 1ps

package csfw_pkg;

  localparam int MAX_WAITERS = 16;
  localparam int PTR_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int COUNT_W     = 18;
  localparam int INIT_W      = 16;
  localparam int ID_W        = 8;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(131071);
  localparam logic signed [COUNT_W-1:0] COUNT_FLOOR = COUNT_W'(-MAX_WAITERS);
  localparam logic [PTR_W-1:0]          PTR_LAST    = PTR_W'(MAX_WAITERS - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_DEC = 2'd0,
    CMD_TRY = 2'd1,
    CMD_INC = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED   = 3'd0,
    ST_BLOCKED    = 3'd1,
    ST_TRY_FAILED = 3'd2,
    ST_RELEASED   = 3'd3,
    ST_WOKE       = 3'd4,
    ST_ERROR      = 3'd5
  } status_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // evaluate request and update state
  } csfw_cmd_t;

endpackage

@@ rtl/core/csfw_ctrl.sv @@
// Request sequencer: accept, execute, present result.
`timescale 1ns / 1ps

module csfw_ctrl
  import csfw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output csfw_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  // Decode datapath commands
  always_comb begin
    cmd_o.capture = in_valid_i & in_ready_q;
    cmd_o.execute = (state_q == S_EXEC);
  end

  // Hold state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q     <= S_OUT;
          out_valid_q <= 1'b1;
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
          in_ready_q  <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/csfw_datapath.sv @@
// Semaphore count, waiter ring and result registers.
`timescale 1ns / 1ps

module csfw_datapath
  import csfw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csfw_cmd_t           cmd_i,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [ID_W-1:0]     task_id_i,
  input  logic                cfg_wr_en_i,
  input  logic [INIT_W-1:0]   cfg_wr_data_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [ID_W-1:0]     woken_task_o
);

  logic [CMD_W-1:0]          command_q;
  logic [ID_W-1:0]           task_id_q;
  logic signed [COUNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0]          head_q, head_d;
  logic [PTR_W-1:0]          tail_q, tail_d;
  logic [ID_W-1:0]           wait_mem [MAX_WAITERS];
  logic [STATUS_W-1:0]       status_q;
  logic [ID_W-1:0]           woken_q;

  status_e status_d;
  logic    push;
  logic    pop;
  logic    cnt_pos;
  logic    can_queue;
  logic    below_max;

  // Condition flags on the current count
  assign cnt_pos   = (count_q > 0);
  assign can_queue = (count_q > COUNT_FLOOR);
  assign below_max = (count_q != COUNT_MAX);

  // Decide the outcome of the latched request
  always_comb begin
    status_d = ST_ERROR;
    count_d  = count_q;
    push     = 1'b0;
    pop      = 1'b0;
    case (cmd_e'(command_q))
      CMD_DEC: begin
        if (cnt_pos) begin
          status_d = ST_ACQUIRED;
          count_d  = count_q - COUNT_W'(1);
        end else if (can_queue) begin
          status_d = ST_BLOCKED;
          count_d  = count_q - COUNT_W'(1);
          push     = 1'b1;
        end
      end
      CMD_TRY: begin
        if (cnt_pos) begin
          status_d = ST_ACQUIRED;
          count_d  = count_q - COUNT_W'(1);
        end else begin
          status_d = ST_TRY_FAILED;
        end
      end
      CMD_INC: begin
        if (below_max) begin
          count_d = count_q + COUNT_W'(1);
          if (count_q < 0) begin
            status_d = ST_WOKE;
            pop      = 1'b1;
          end else begin
            status_d = ST_RELEASED;
          end
        end
      end
      default: status_d = ST_ERROR;
    endcase
  end

  // Advance ring pointers with wrap
  assign tail_d = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
  assign head_d = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;

  // Hold count and pointers; reload on a configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
    end else if (cfg_wr_en_i) begin
      count_q <= COUNT_W'(cfg_wr_data_i);
      head_q  <= '0;
      tail_q  <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
      if (push) tail_q <= tail_d;
      if (pop)  head_q <= head_d;
    end
  end

  // Latch request, write waiter ring, register result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      command_q <= command_i;
      task_id_q <= task_id_i;
    end
    if (cmd_i.execute) begin
      if (push) wait_mem[tail_q] <= task_id_q;
      status_q <= status_d;
      woken_q  <= pop ? wait_mem[head_q] : '0;
    end
  end

  assign status_o     = status_q;
  assign woken_task_o = woken_q;

endmodule

@@ rtl/core/counting_semaphore_fifo_waiters.sv @@
// Top level of the counting semaphore with a FIFO wait queue.
//
//  Channel  | Dir | Signals                         | Contents
//  ---------+-----+---------------------------------+---------------------------------
//  s_axis   | in  | tvalid/tready/tdata/tuser       | tdata: task_id; tuser: command
//  m_axis   | out | tvalid/tready/tdata/tuser       | tdata: woken_task; tuser: status
//  cfg      | in  | cfg_wr_en_i/cfg_wr_data_i       | initial_count, reloads semaphore
//
// Each request passes three steps: accept, execute, present (held while m_axis stalls).
// The sequencer holds one request at a time; s_axis_tready returns only after
// the result transaction on m_axis completes.
// Reset (rst_ni low, asynchronous) clears the count to zero and empties the queue.
// A configuration write loads the count and empties the queue.
`timescale 1ns / 1ps

`include "counting_semaphore_fifo_waiters_macros.svh"

module counting_semaphore_fifo_waiters
  import csfw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] task_id
  input  logic [CMD_W-1:0]    s_axis_tuser,   // [1:0] command
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] woken_task
  output logic [STATUS_W-1:0] m_axis_tuser,   // [2:0] status
  input  logic                cfg_wr_en_i,
  input  logic [INIT_W-1:0]   cfg_wr_data_i
);

  csfw_cmd_t cmd;

  csfw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  csfw_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .command_i     (s_axis_tuser),
    .task_id_i     (s_axis_tdata[ID_W-1:0]),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .status_o      (m_axis_tuser),
    .woken_task_o  (m_axis_tdata)
  );

  // Sequencing and result checks
  `CSFW_ASSERT_NXT(a_capture_then_exec, clk_i, rst_ni, cmd.capture, cmd.execute)
  `CSFW_ASSERT_NXT(a_exec_then_valid, clk_i, rst_ni, cmd.execute, m_axis_tvalid)
  `CSFW_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, m_axis_tvalid || cmd.execute, !s_axis_tready)
  `CSFW_ASSERT_IMP(a_woken_only_on_wake, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_WOKE), m_axis_tdata == '0)

endmodule
